// ===== src/softmax_top1_with_class_stats_assert.svh =====
// Assertion macros for the top-1 softmax classifier.
// Included by the top level; no other dependencies.
`ifndef SOFTMAX_TOP1_WITH_CLASS_STATS_ASSERT_SVH
`define SOFTMAX_TOP1_WITH_CLASS_STATS_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SMX_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("smx assertion failed");
// Next-cycle implication.
`define SMX_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("smx assertion failed");
`else
`define SMX_ASSERT_IMP(label, clk, rst_n, a, b)
`define SMX_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== src/smx_pkg.sv =====
// Shared constants and the exp table generator of the softmax classifier.
// No dependencies.
`default_nettype none
package smx_pkg;
  localparam int NUM_CLASSES_DEF     = 16;
  localparam int LOGIT_BITS_DEF      = 16;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam int CMD_W   = 1;
  localparam int FRAME_W = 32;
  localparam int TS_W    = 64;
  localparam int CLS_W   = 4;
  localparam int CONF_W  = 15;
  localparam int HIT_W   = 32;
  localparam int TOT_W   = 48;
  localparam int EXP_W   = 17;

  localparam logic [CONF_W-1:0] PCT_SCALE = 15'd25600;
  localparam logic [HIT_W-1:0]  HIT_MAX   = {HIT_W{1'b1}};
  localparam logic [TOT_W-1:0]  TOT_MAX   = {TOT_W{1'b1}};
  localparam logic [63:0]       EXP_RATIO = 64'd4034748382;

  localparam logic [CMD_W-1:0] CMD_LOGIT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

  // Entry k approximates exp(-k/16) in Q1.16; evaluated at elaboration only.
  function automatic logic [EXP_W-1:0] exp_entry(input int k);
    logic [63:0] acc;
    logic [63:0] rnd;
    acc = 64'h1_0000_0000;
    for (int j = 0; j < k; j++) begin
      acc = ((acc * EXP_RATIO) + 64'h8000_0000) >> 32;
    end
    rnd = (acc + 64'h8000) >> 16;
    return rnd[EXP_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== src/smx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/smx_div.sv =====
// Restoring divider, one quotient bit per cycle, for the confidence ratio.
// The caller guarantees the quotient fits in QUOT_W bits.
`default_nettype none
module smx_div #(
  parameter int DVD_W  = 33,
  parameter int DIV_W  = 21,
  parameter int QUOT_W = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DVD_W-1:0]  dividend_i,
  input  wire logic [DIV_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic      [QUOT_W-1:0] quotient_o
);
  localparam int CW = $clog2(QUOT_W + 1);

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] lo_q, lo_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVD_W-1:0]  hi_part;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign hi_part = dividend_i >> QUOT_W;
  assign trial   = {rem_q, lo_q[QUOT_W-1]};
  assign fits    = trial >= {1'b0, dvs_q};

  // One restoring step per cycle.
  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = hi_part[DIV_W-1:0];
      lo_d   = dividend_i[QUOT_W-1:0];
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DIV_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
      lo_d  = {lo_q[QUOT_W-2:0], 1'b0};
      quo_d = {quo_q[QUOT_W-2:0], fits};
      cnt_d = CW'(cnt_q + 1'b1);
      if (cnt_q == CW'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// ===== src/softmax_top1_with_class_stats.sv =====
// Logits load one per cycle while the sequencer is in its load state. The result then
// follows a scan of the n stored elements (n at most NUM_CLASSES) through the logit RAM,
// a set-up state, the bit-serial divider and a stats read-modify-write (read, then write).
// No new logits are taken until the last result is stored, which waits for a free output;
// the logit RAM has a single read port and the divider works one quotient bit at a time.
// Reset clears control state, statistics valid bits and counters; no clearing pass.
`default_nettype none
`include "softmax_top1_with_class_stats_assert.svh"
module softmax_top1_with_class_stats #(
  parameter int NUM_CLASSES     = smx_pkg::NUM_CLASSES_DEF,
  parameter int LOGIT_BITS      = smx_pkg::LOGIT_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = smx_pkg::EXP_TABLE_DEPTH_DEF,
  localparam int IN_W  = ((LOGIT_BITS + smx_pkg::FRAME_W + smx_pkg::TS_W + 7) / 8) * 8,
  localparam int OUT_W = 184
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: logit, frame_number, timestamp (lowest bit first), zero padded
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             s_axis_tlast,
  // tuser: command
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // tdata: best_class, confidence_pct, frame_echo, time_echo, time_valid,
  //        lead_class, majority_count, total_count (lowest bit first)
  output logic      [OUT_W-1:0] m_axis_tdata
);
  localparam int AW   = $clog2(NUM_CLASSES);
  localparam int CW   = $clog2(NUM_CLASSES + 1);
  localparam int TW   = $clog2(EXP_TABLE_DEPTH);
  localparam int EW   = smx_pkg::EXP_W;
  localparam int SW   = EW + AW;
  localparam int DVDW = (SW > 32 ? SW : 32) + 1;
  localparam int SMW  = smx_pkg::HIT_W + smx_pkg::TOT_W;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_STRD = 3'd4;
  localparam logic [2:0] ST_STWR = 3'd5;

  localparam logic signed [LOGIT_BITS-1:0] LOGIT_MIN = {1'b1, {(LOGIT_BITS-1){1'b0}}};

  // Exp table as constant logic.
  logic [EW-1:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    assign exp_tab[g] = smx_pkg::exp_entry(g);
  end

  // Input beat fields.
  logic signed [LOGIT_BITS-1:0]    in_logit;
  logic [smx_pkg::FRAME_W-1:0]     in_frame;
  logic [smx_pkg::TS_W-1:0]        in_ts;
  logic                            in_acc;
  assign in_logit = s_axis_tdata[LOGIT_BITS-1:0];
  assign in_frame = s_axis_tdata[LOGIT_BITS +: smx_pkg::FRAME_W];
  assign in_ts    = s_axis_tdata[LOGIT_BITS + smx_pkg::FRAME_W +: smx_pkg::TS_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  logic [2:0]                      state_q, state_d;
  logic [CW-1:0]                   elem_q, elem_d;
  logic signed [LOGIT_BITS-1:0]    max_q, max_d;
  logic [smx_pkg::FRAME_W-1:0]     frame_q, frame_d;
  logic [smx_pkg::TS_W-1:0]        ts_q, ts_d;
  logic [CW-1:0]                   scan_q, scan_d;
  logic                            p1_vld_q, p1_vld_d;
  logic [AW-1:0]                   p1_idx_q, p1_idx_d;
  logic                            p2_vld_q, p2_vld_d;
  logic [AW-1:0]                   p2_idx_q, p2_idx_d;
  logic [EW-1:0]                   e_q, e_d;
  logic [SW-1:0]                   sum_q, sum_d;
  logic [EW-1:0]                   best_e_q, best_e_d;
  logic [AW-1:0]                   best_q, best_d;
  logic [smx_pkg::CONF_W-1:0]      conf_q, conf_d;
  logic [NUM_CLASSES-1:0]          svld_q, svld_d;
  logic [AW-1:0]                   maj_q, maj_d;
  logic [smx_pkg::HIT_W-1:0]       majc_q, majc_d;
  logic [smx_pkg::HIT_W-1:0]       total_q, total_d;
  logic                            mvld_q, mvld_d;
  logic [OUT_W-1:0]                mdat_q, mdat_d;

  // Logit store.
  logic                            lw_we;
  logic [LOGIT_BITS-1:0]           lw_rdata;
  assign lw_we = in_acc && (s_axis_tuser == smx_pkg::CMD_LOGIT) &&
                 (elem_q < CW'(NUM_CLASSES));

  smx_ram #(.WIDTH(LOGIT_BITS), .DEPTH(NUM_CLASSES)) u_logit_ram (
    .clk_i  (clk_i),
    .we_i   (lw_we),
    .waddr_i(elem_q[AW-1:0]),
    .wdata_i(in_logit),
    .raddr_i(scan_q[AW-1:0]),
    .rdata_o(lw_rdata)
  );

  // Per-class statistics store: confidence total above hit count.
  logic                            st_we;
  logic [SMW-1:0]                  st_wdata;
  logic [SMW-1:0]                  st_rdata;

  smx_ram #(.WIDTH(SMW), .DEPTH(NUM_CLASSES)) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(best_q),
    .wdata_i(st_wdata),
    .raddr_i(best_q),
    .rdata_o(st_rdata)
  );

  // Distance to the maximum and exp lookup.
  logic [33:0]                     gap;
  logic [33:0]                     eidx;
  logic [EW-1:0]                   e_lookup;
  assign gap      = 34'($signed(max_q) - $signed(lw_rdata));
  assign eidx     = (gap + 34'd8) >> 4;
  assign e_lookup = (eidx < 34'(EXP_TABLE_DEPTH)) ? exp_tab[eidx[TW-1:0]] : '0;

  // Divider operands: rounded ratio of scaled best term over the sum.
  logic [DVDW-1:0]                 div_num;
  logic                            div_done;
  logic [smx_pkg::CONF_W-1:0]      div_quo;
  assign div_num = DVDW'(best_e_q * smx_pkg::PCT_SCALE) + DVDW'(sum_q >> 1);

  smx_div #(.DVD_W(DVDW), .DIV_W(SW), .QUOT_W(smx_pkg::CONF_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_MUL),
    .dividend_i(div_num),
    .divisor_i (sum_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Statistics update values.
  logic [smx_pkg::HIT_W-1:0]       hits_old, hits_new;
  logic [smx_pkg::TOT_W-1:0]       tot_old, tot_new;
  logic                            out_free;
  assign hits_old = svld_q[best_q] ? st_rdata[smx_pkg::HIT_W-1:0] : '0;
  assign tot_old  = svld_q[best_q] ? st_rdata[SMW-1:smx_pkg::HIT_W] : '0;
  assign hits_new = (hits_old == smx_pkg::HIT_MAX) ? hits_old
                                                   : smx_pkg::HIT_W'(hits_old + 1'b1);
  assign tot_new  = (tot_old > smx_pkg::TOT_MAX - smx_pkg::TOT_W'(conf_q)) ? smx_pkg::TOT_MAX
                  : smx_pkg::TOT_W'(tot_old + smx_pkg::TOT_W'(conf_q));
  assign st_wdata = {tot_new, hits_new};
  assign out_free = !mvld_q || m_axis_tready;
  assign st_we    = (state_q == ST_STWR) && out_free;
  assign s_axis_tready = (state_q == ST_LOAD);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    elem_d   = elem_q;
    max_d    = max_q;
    frame_d  = frame_q;
    ts_d     = ts_q;
    scan_d   = scan_q;
    p1_vld_d = 1'b0;
    p1_idx_d = p1_idx_q;
    p2_vld_d = p1_vld_q;
    p2_idx_d = p1_idx_q;
    e_d      = e_lookup;
    sum_d    = sum_q;
    best_e_d = best_e_q;
    best_d   = best_q;
    conf_d   = conf_q;
    svld_d   = svld_q;
    maj_d    = maj_q;
    majc_d   = majc_q;
    total_d  = total_q;
    mvld_d   = mvld_q && !m_axis_tready;
    mdat_d   = mdat_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (s_axis_tuser == smx_pkg::CMD_CLEAR) begin
            svld_d  = '0;
            maj_d   = '0;
            majc_d  = '0;
            total_d = '0;
          end else begin
            if (elem_q < CW'(NUM_CLASSES)) begin
              elem_d = CW'(elem_q + 1'b1);
              if (in_logit > max_q) begin
                max_d = in_logit;
              end
            end
            if (s_axis_tlast) begin
              frame_d = in_frame;
              ts_d    = in_ts;
              scan_d  = '0;
              sum_d   = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_q < elem_q) begin
          p1_vld_d = 1'b1;
          p1_idx_d = scan_q[AW-1:0];
          scan_d   = CW'(scan_q + 1'b1);
        end
        if (p2_vld_q) begin
          sum_d = SW'(sum_q + SW'(e_q));
          if (p2_idx_q == '0 || e_q > best_e_q) begin
            best_e_d = e_q;
            best_d   = p2_idx_q;
          end
        end
        if (scan_q == elem_q && !p1_vld_q && !p2_vld_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (sum_q == '0) begin
            conf_d = '0;
          end else if (div_quo > smx_pkg::PCT_SCALE) begin
            conf_d = smx_pkg::PCT_SCALE;
          end else begin
            conf_d = div_quo;
          end
          state_d = ST_STRD;
        end
      end
      ST_STRD: begin
        state_d = ST_STWR;
      end
      ST_STWR: begin
        if (out_free) begin
          svld_d[best_q] = 1'b1;
          if (total_q != smx_pkg::HIT_MAX) begin
            total_d = smx_pkg::HIT_W'(total_q + 1'b1);
          end
          if (best_q == maj_q) begin
            majc_d = hits_new;
          end else if (hits_new > majc_q || (hits_new == majc_q && best_q < maj_q)) begin
            maj_d  = best_q;
            majc_d = hits_new;
          end
          mvld_d = 1'b1;
          mdat_d = {total_d, majc_d, smx_pkg::CLS_W'(maj_d),
                    (ts_q != {smx_pkg::TS_W{1'b1}}), ts_q, frame_q, conf_q,
                    smx_pkg::CLS_W'(best_q)};
          elem_d  = '0;
          max_d   = LOGIT_MIN;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      elem_q   <= '0;
      max_q    <= LOGIT_MIN;
      scan_q   <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      svld_q   <= '0;
      maj_q    <= '0;
      majc_q   <= '0;
      total_q  <= '0;
      mvld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      elem_q   <= elem_d;
      max_q    <= max_d;
      scan_q   <= scan_d;
      p1_vld_q <= p1_vld_d;
      p2_vld_q <= p2_vld_d;
      svld_q   <= svld_d;
      maj_q    <= maj_d;
      majc_q   <= majc_d;
      total_q  <= total_d;
      mvld_q   <= mvld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    ts_q     <= ts_d;
    p1_idx_q <= p1_idx_d;
    p2_idx_q <= p2_idx_d;
    e_q      <= e_d;
    sum_q    <= sum_d;
    best_e_q <= best_e_d;
    best_q   <= best_d;
    conf_q   <= conf_d;
    mdat_q   <= mdat_d;
  end

  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = mdat_q;

  // Checks on the sequencer and the statistics.
  `SMX_ASSERT_IMP(a_elem_bound, clk_i, rst_ni, 1'b1, elem_q <= CW'(NUM_CLASSES))
  `SMX_ASSERT_IMP(a_maj_le_total, clk_i, rst_ni, 1'b1, majc_q <= total_q)
  `SMX_ASSERT_NXT(a_result_loaded, clk_i, rst_ni, st_we, m_axis_tvalid)
  `SMX_ASSERT_IMP(a_conf_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[18:4] <= smx_pkg::PCT_SCALE)
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the top-1 softmax classifier with class statistics.
// Depends on smx_pkg and the softmax_top1_with_class_stats top level.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: mirrors the classifier state and holds the predicted result beats.
class smx_scoreboard;
  logic signed [15:0] logit_mem [16];
  int unsigned        elem_cnt;
  logic signed [15:0] peak;
  logic [31:0]        hits [16];
  logic [47:0]        conf_sum [16];
  logic [31:0]        infer_cnt;
  logic [3:0]         maj_cls;
  logic [16:0]        exp_tab [256];
  logic [183:0]       pending [$];
  int                 errors;

  function new();
    logic [63:0] acc;
    acc = 64'h1_0000_0000;
    for (int k = 0; k < 256; k++) begin
      exp_tab[k] = 17'((acc + 64'h8000) >> 16);
      acc = (acc * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    elem_cnt = 0;
    peak = 16'sh8000;
    errors = 0;
    clear_stats();
  endfunction

  function void clear_stats();
    for (int i = 0; i < 16; i++) begin
      hits[i] = '0;
      conf_sum[i] = '0;
    end
    infer_cnt = '0;
    maj_cls = '0;
  endfunction

  // Note one accepted input beat and predict the result it causes, if any.
  function void note_input(logic cmd, logic signed [15:0] lg, logic lst,
                           logic [31:0] frame, logic [63:0] ts);
    logic [63:0] sum, num, q, gap, idx;
    logic [16:0] e, best_e;
    logic [3:0]  best;
    logic [14:0] conf;
    if (cmd == smx_pkg::CMD_CLEAR) begin
      clear_stats();
      return;
    end
    if (elem_cnt < 16) begin
      logit_mem[elem_cnt] = lg;
      if (lg > peak) peak = lg;
      elem_cnt++;
    end
    if (!lst) return;
    sum = 0;
    best = 0;
    best_e = 0;
    for (int i = 0; i < elem_cnt; i++) begin
      gap = 64'(int'(peak) - int'(logit_mem[i]));
      idx = (gap + 8) >> 4;
      e = (idx >= 256) ? 17'd0 : exp_tab[idx];
      sum += e;
      if (i == 0 || e > best_e) begin
        best_e = e;
        best = 4'(i);
      end
    end
    if (sum == 0) begin
      conf = 0;
    end else begin
      num = 64'd25600 * best_e;
      q = (num + sum / 2) / sum;
      conf = (q > 25600) ? 15'd25600 : 15'(q);
    end
    if (hits[best] != 32'hFFFF_FFFF) hits[best]++;
    if (conf_sum[best] > 48'hFFFF_FFFF_FFFF - conf) conf_sum[best] = 48'hFFFF_FFFF_FFFF;
    else conf_sum[best] += conf;
    if (infer_cnt != 32'hFFFF_FFFF) infer_cnt++;
    maj_cls = 0;
    for (int i = 1; i < 16; i++)
      if (hits[i] > hits[maj_cls]) maj_cls = 4'(i);
    pending.push_back({infer_cnt, hits[maj_cls], maj_cls, (ts != '1), ts, frame, conf, best});
    elem_cnt = 0;
    peak = 16'sh8000;
  endfunction

  // Compare one result beat, field by field, with the oldest prediction.
  function void check_result(logic [183:0] got);
    logic [183:0] exp_beat;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_beat = pending.pop_front();
    if (got[3:0] !== exp_beat[3:0]) begin
      $display("%0t: best_class exp %0d got %0d", $time, exp_beat[3:0], got[3:0]);
      errors++;
    end
    if (got[18:4] !== exp_beat[18:4]) begin
      $display("%0t: confidence_pct exp %0d got %0d", $time, exp_beat[18:4], got[18:4]);
      errors++;
    end
    if (got[50:19] !== exp_beat[50:19]) begin
      $display("%0t: frame_echo exp %h got %h", $time, exp_beat[50:19], got[50:19]);
      errors++;
    end
    if (got[114:51] !== exp_beat[114:51]) begin
      $display("%0t: time_echo exp %h got %h", $time, exp_beat[114:51], got[114:51]);
      errors++;
    end
    if (got[115] !== exp_beat[115]) begin
      $display("%0t: time_valid exp %b got %b", $time, exp_beat[115], got[115]);
      errors++;
    end
    if (got[119:116] !== exp_beat[119:116]) begin
      $display("%0t: lead_class exp %0d got %0d", $time, exp_beat[119:116],
               got[119:116]);
      errors++;
    end
    if (got[151:120] !== exp_beat[151:120]) begin
      $display("%0t: majority_count exp %0d got %0d", $time, exp_beat[151:120],
               got[151:120]);
      errors++;
    end
    if (got[183:152] !== exp_beat[183:152]) begin
      $display("%0t: total_count exp %0d got %0d", $time, exp_beat[183:152],
               got[183:152]);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int IN_W = 112;
  localparam int CYCLE_LIMIT = 400000;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic            s_axis_tlast;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [183:0]    m_axis_tdata;

  smx_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  cycle_cnt;

  softmax_top1_with_class_stats u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one input beat, idling beforehand at the current rate.
  // The valid stays high after the beat, so back-to-back beats need no second update.
  task automatic send_beat(logic cmd, logic signed [15:0] lg, logic lst,
                           logic [31:0] frame, logic [63:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {ts, frame, lg};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(cmd, lg, lst, frame, ts);
  endtask

  function automatic logic [63:0] rand_ts();
    case ($urandom_range(3))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Logit near a base value half the time, so that several classes share the probability.
  function automatic logic signed [15:0] rand_logit(logic signed [15:0] base);
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      default: return base + 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // One inference of n elements with random content.
  task automatic send_inference(int n);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < n; i++)
      send_beat(smx_pkg::CMD_LOGIT, rand_logit(base), i == n - 1, $urandom, rand_ts());
  endtask

  // Random stimulus for one idling phase.
  task automatic random_phase(int beats);
    int sent;
    int n;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(19) == 0) begin
        send_beat(smx_pkg::CMD_CLEAR, 16'($urandom), 1'($urandom_range(1)), $urandom,
                  rand_ts());
        sent++;
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        send_inference(n);
        sent += n;
      end
    end
  endtask

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long hold-off, counted in its own process, while the sender keeps going.
  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main stimulus.
  initial begin
    sb = new();
    cycle_cnt = 0;
    send_idle_pct = 8;
    recv_idle_pct = 58;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single element, extremes, ties, far distances, extra elements, clears.
    send_beat(smx_pkg::CMD_LOGIT, 16'sh8000, 1'b1, '0, '1);
    send_beat(smx_pkg::CMD_LOGIT, 16'sh7FFF, 1'b0, '1, '0);
    send_beat(smx_pkg::CMD_LOGIT, 16'sh8000, 1'b1, '1, '0);
    send_beat(smx_pkg::CMD_LOGIT, 16'sh0100, 1'b0, 32'd5, 64'd7);
    send_beat(smx_pkg::CMD_LOGIT, 16'sh0100, 1'b0, 32'd5, 64'd7);
    send_beat(smx_pkg::CMD_LOGIT, 16'sh0100, 1'b1, 32'd6, 64'hFFFF_FFFF_FFFF_FFFE);
    send_beat(smx_pkg::CMD_CLEAR, 16'sh7FFF, 1'b1, '1, '1);
    for (int i = 0; i < 18; i++)
      send_beat(smx_pkg::CMD_LOGIT, (i == 9) ? 16'sh0200 : 16'sh0000, i == 17,
                32'(i), 64'(i));
    send_beat(smx_pkg::CMD_LOGIT, 16'sh0007, 1'b0, '0, '0);
    send_beat(smx_pkg::CMD_CLEAR, '0, 1'b0, '0, '0);
    send_beat(smx_pkg::CMD_LOGIT, 16'sh0000, 1'b1, 32'hA5A5_5A5A, 64'h1234);

    random_phase(450);
    send_idle_pct = 58;
    recv_idle_pct = 8;
    random_phase(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(350);

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/smx_pkg.sv
src/smx_ram.sv
src/smx_div.sv
src/softmax_top1_with_class_stats.sv
tb/sv/tb.sv
